// ----- rtl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared codes and types of the dual-stack machine: commands, opcodes,
// port-5 query codes and the divider request/response bundles.
// ----------------------------------------------------------------------------
package dsm_pkg;

    // commands
    localparam logic [2:0] CMD_MEM_WR  = 3'd0;
    localparam logic [2:0] CMD_MEM_RD  = 3'd1;
    localparam logic [2:0] CMD_EXEC    = 3'd2;
    localparam logic [2:0] CMD_PORT_WR = 3'd3;
    localparam logic [2:0] CMD_PORT_RD = 3'd4;

    // opcodes
    localparam logic [31:0] OP_NOP    = 32'd0;
    localparam logic [31:0] OP_LIT    = 32'd1;
    localparam logic [31:0] OP_DUP    = 32'd2;
    localparam logic [31:0] OP_DROP   = 32'd3;
    localparam logic [31:0] OP_SWAP   = 32'd4;
    localparam logic [31:0] OP_PUSH   = 32'd5;
    localparam logic [31:0] OP_POP    = 32'd6;
    localparam logic [31:0] OP_LOOP   = 32'd7;
    localparam logic [31:0] OP_JUMP   = 32'd8;
    localparam logic [31:0] OP_RETURN = 32'd9;
    localparam logic [31:0] OP_GT_JMP = 32'd10;
    localparam logic [31:0] OP_LT_JMP = 32'd11;
    localparam logic [31:0] OP_NE_JMP = 32'd12;
    localparam logic [31:0] OP_EQ_JMP = 32'd13;
    localparam logic [31:0] OP_FETCH  = 32'd14;
    localparam logic [31:0] OP_STORE  = 32'd15;
    localparam logic [31:0] OP_ADD    = 32'd16;
    localparam logic [31:0] OP_SUB    = 32'd17;
    localparam logic [31:0] OP_MUL    = 32'd18;
    localparam logic [31:0] OP_DIVMOD = 32'd19;
    localparam logic [31:0] OP_AND    = 32'd20;
    localparam logic [31:0] OP_OR     = 32'd21;
    localparam logic [31:0] OP_XOR    = 32'd22;
    localparam logic [31:0] OP_SHL    = 32'd23;
    localparam logic [31:0] OP_SHR    = 32'd24;
    localparam logic [31:0] OP_ZEXIT  = 32'd25;
    localparam logic [31:0] OP_INC    = 32'd26;
    localparam logic [31:0] OP_DEC    = 32'd27;
    localparam logic [31:0] OP_IN     = 32'd28;
    localparam logic [31:0] OP_OUT    = 32'd29;
    localparam logic [31:0] OP_WAIT   = 32'd30;

    // port-5 capability queries
    localparam logic [31:0] Q_SIZE   = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_DDEPTH = 32'hFFFF_FFFB;
    localparam logic [31:0] Q_RDEPTH = 32'hFFFF_FFFA;
    localparam logic [31:0] Q_HALT   = 32'hFFFF_FFF7;

    localparam int PORT_QUERY = 5;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/dsm_ram.sv -----
// ----------------------------------------------------------------------------
// dsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dsm_div.sv -----
// ----------------------------------------------------------------------------
// dsm_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  dsm_pkg::div_req_t  req,
    output dsm_pkg::div_rsp_t  rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/dual_stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// dual_stack_machine_core
// 32-bit dual-stack machine: program memory, data and return stacks and
// port bank in RAMs, top of data stack cached in a register.
// ----------------------------------------------------------------------------
// Sequence: memory and port commands go to S_RESULT, reads by way of S_MEMRD;
// an instruction passes S_OP and S_ARG, then may add S_SKIP1 and S_SKIP2 (NOP
// skipping at a JUMP or call target), S_FETCH, S_OUT2, S_WAIT2 for an answered WAIT
// or S_DIV for /MOD (bit-serial divider). Throughput: one item at a time; the next
// transfer is taken once the result sits in the output register. Reset: a sweep
// over the image zeroes program memory and ports; in_ready stays low until it ends.
module dual_stack_machine_core #(
    parameter int IMAGE_WORDS  = 32768,
    parameter int DATA_DEPTH   = 128,
    parameter int RETURN_DEPTH = 1024,
    parameter int PORT_COUNT   = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [14:0] address,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [15:0] next_address,
    output logic [31:0] top_value,
    output logic [7:0]  data_depth,
    output logic [10:0] return_depth,
    output logic        halted,
    output logic        io_request,
    output logic        fault
);

    localparam int AW  = $clog2(IMAGE_WORDS);
    localparam int IPW = $clog2(IMAGE_WORDS + 1);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int RPW = $clog2(RETURN_DEPTH + 1);
    localparam int PAW = $clog2(PORT_COUNT);

    localparam logic [31:0]    Img32  = 32'(IMAGE_WORDS);
    localparam logic [IPW-1:0] ImgIp  = IPW'(IMAGE_WORDS);
    localparam logic [IPW:0]   ImgIpX = (IPW + 1)'(IMAGE_WORDS);
    localparam logic [31:0]    Port32 = 32'(PORT_COUNT);
    localparam logic [DPW-1:0] DMax   = DPW'(DATA_DEPTH);
    localparam logic [RPW-1:0] RMax   = RPW'(RETURN_DEPTH);
    localparam logic [PAW-1:0] PQuery = PAW'(dsm_pkg::PORT_QUERY);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MEMRD, S_OP, S_ARG, S_FETCH, S_SKIP1, S_SKIP2,
        S_DIV, S_OUT2, S_WAIT2, S_RESULT
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [IPW-1:0] ip_reg, ip_next;
    logic [DPW-1:0] dp_reg, dp_next;
    logic [RPW-1:0] rp_reg, rp_next;
    logic [31:0]    top_reg, top_next;
    logic           stop_reg, stop_next;
    logic           fault_reg, fault_next;

    // per-item working registers
    logic [IPW-1:0] clr_reg, clr_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [14:0]    addr_reg, addr_next;
    logic [31:0]    op_reg, op_next;
    logic [31:0]    nos_reg, nos_next;
    logic [31:0]    rtop_reg, rtop_next;
    logic [31:0]    p0_reg, p0_next;
    logic           argok_reg, argok_next;
    logic [IPW-1:0] tgt_reg, tgt_next;
    logic           whalt_reg, whalt_next;
    logic [31:0]    rd_reg, rd_next;
    logic           io_reg, io_next;

    // output register
    logic        ov_reg, ov_next;
    logic [31:0] o_rd_reg, o_rd_next;
    logic [IPW-1:0] o_ip_reg, o_ip_next;
    logic [31:0] o_top_reg, o_top_next;
    logic [DPW-1:0] o_dp_reg, o_dp_next;
    logic [RPW-1:0] o_rp_reg, o_rp_next;
    logic        o_halt_reg, o_halt_next;
    logic        o_io_reg, o_io_next;
    logic        o_fault_reg, o_fault_next;

    // RAM ports
    logic           pm_we;
    logic [AW-1:0]  pm_waddr, pm_raddr;
    logic [31:0]    pm_wdata, pm_rdata;
    logic           ds_we;
    logic [DAW-1:0] ds_waddr, ds_raddr;
    logic [31:0]    ds_wdata, ds_rdata;
    logic           rs_we;
    logic [RAW-1:0] rs_waddr, rs_raddr;
    logic [31:0]    rs_wdata, rs_rdata;
    logic           pt_we;
    logic [PAW-1:0] pt_waddr, pt_raddr;
    logic [31:0]    pt_wdata, pt_rdata;

    dsm_pkg::div_req_t div_req;
    dsm_pkg::div_rsp_t div_rsp;

    // helpers
    logic [31:0]    in_addr32, addr32, ip32, ip1_32;
    logic [DPW-1:0] dp_m1, dp_m2;
    logic [RPW-1:0] rp_m1;
    logic           d_pop1, d_pop2, d_push, r_pop, r_push;
    logic [31:0]    arg_w, nos2_w, pdat_w, alu_w, loop_n;
    logic           taken_w;
    logic [31:0]    ua_w, ub_w, q_w, r_w;
    logic           fin, flt;
    logic [IPW:0]   ip_fin, skip_t;
    logic           goto_req, goto_skip, goto_bad;
    logic [31:0]    goto_t;

    dsm_ram #(.WIDTH(32), .DEPTH(IMAGE_WORDS)) u_pmem (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );
    dsm_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dstack (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );
    dsm_ram #(.WIDTH(32), .DEPTH(RETURN_DEPTH)) u_rstack (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );
    dsm_ram #(.WIDTH(32), .DEPTH(PORT_COUNT)) u_ports (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    dsm_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    // derived values
    assign in_addr32 = 32'(address);
    assign addr32    = 32'(addr_reg);
    assign ip32      = 32'(ip_reg);
    assign ip1_32    = ip32 + 32'd1;
    assign dp_m1     = dp_reg - 1'b1;
    assign dp_m2     = dp_reg - DPW'(2);
    assign rp_m1     = rp_reg - 1'b1;
    assign d_pop1    = (dp_reg != '0);
    assign d_pop2    = (dp_reg >= DPW'(2));
    assign d_push    = (dp_reg != DMax);
    assign r_pop     = (rp_reg != '0);
    assign r_push    = (rp_reg != RMax);
    assign arg_w     = argok_reg ? pm_rdata : 32'd0;
    assign nos2_w    = ds_rdata;
    assign pdat_w    = pt_rdata;
    assign loop_n    = top_reg - 32'd1;
    assign ua_w      = top_reg[31] ? (32'd0 - top_reg) : top_reg;
    assign ub_w      = nos_reg[31] ? (32'd0 - nos_reg) : nos_reg;
    assign q_w       = (top_reg[31] ^ nos_reg[31]) ? (32'd0 - div_rsp.quotient)
                                                   : div_rsp.quotient;
    assign r_w       = nos_reg[31] ? (32'd0 - div_rsp.remainder) : div_rsp.remainder;
    assign goto_bad  = goto_t[31] || (goto_t >= Img32);
    assign skip_t    = {1'b0, tgt_reg} + 1'b1;

    // binary ALU: nos op top
    always_comb
    begin
        case (op_reg)
            dsm_pkg::OP_ADD: alu_w = nos_reg + top_reg;
            dsm_pkg::OP_SUB: alu_w = nos_reg - top_reg;
            dsm_pkg::OP_MUL: alu_w = nos_reg * top_reg;
            dsm_pkg::OP_AND: alu_w = nos_reg & top_reg;
            dsm_pkg::OP_OR:  alu_w = nos_reg | top_reg;
            dsm_pkg::OP_XOR: alu_w = nos_reg ^ top_reg;
            dsm_pkg::OP_SHL: alu_w = nos_reg << top_reg[4:0];
            dsm_pkg::OP_SHR: alu_w = $unsigned($signed(nos_reg) >>> top_reg[4:0]);
            default:         alu_w = '0;
        endcase
    end

    // compare-jump condition (a = top, b = nos)
    always_comb
    begin
        case (op_reg)
            dsm_pkg::OP_GT_JMP: taken_w = $signed(top_reg) < $signed(nos_reg);
            dsm_pkg::OP_LT_JMP: taken_w = $signed(nos_reg) < $signed(top_reg);
            dsm_pkg::OP_NE_JMP: taken_w = top_reg != nos_reg;
            dsm_pkg::OP_EQ_JMP: taken_w = top_reg == nos_reg;
            default:            taken_w = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ip_next    = ip_reg;
        dp_next    = dp_reg;
        rp_next    = rp_reg;
        top_next   = top_reg;
        stop_next  = stop_reg;
        fault_next = fault_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        op_next    = op_reg;
        nos_next   = nos_reg;
        rtop_next  = rtop_reg;
        p0_next    = p0_reg;
        argok_next = argok_reg;
        tgt_next   = tgt_reg;
        whalt_next = whalt_reg;
        rd_next    = rd_reg;
        io_next    = io_reg;

        ov_next      = ov_reg & ~out_ready;
        o_rd_next    = o_rd_reg;
        o_ip_next    = o_ip_reg;
        o_top_next   = o_top_reg;
        o_dp_next    = o_dp_reg;
        o_rp_next    = o_rp_reg;
        o_halt_next  = o_halt_reg;
        o_io_next    = o_io_reg;
        o_fault_next = o_fault_reg;

        pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_raddr = ip_reg[AW-1:0];
        ds_we = 1'b0; ds_waddr = '0; ds_wdata = '0; ds_raddr = dp_m1[DAW-1:0];
        rs_we = 1'b0; rs_waddr = '0; rs_wdata = '0; rs_raddr = rp_m1[RAW-1:0];
        pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_raddr = '0;

        div_req.start    = 1'b0;
        div_req.dividend = ub_w;
        div_req.divisor  = ua_w;

        fin       = 1'b0;
        flt       = 1'b0;
        ip_fin    = {1'b0, ip_reg} + 1'b1;
        goto_req  = 1'b0;
        goto_skip = 1'b0;
        goto_t    = '0;

        case (state_reg)
            // zero program memory and ports after reset
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg[AW-1:0];
                pt_we    = (32'(clr_reg) < Port32);
                pt_waddr = clr_reg[PAW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ImgIp - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command;
                    addr_next = address;
                    rd_next   = '0;
                    io_next   = 1'b0;
                    case (command)
                        dsm_pkg::CMD_MEM_WR:
                        begin
                            pm_we      = (in_addr32 < Img32);
                            pm_waddr   = in_addr32[AW-1:0];
                            pm_wdata   = value;
                            state_next = S_RESULT;
                        end
                        dsm_pkg::CMD_MEM_RD:
                        begin
                            pm_raddr   = in_addr32[AW-1:0];
                            state_next = S_MEMRD;
                        end
                        dsm_pkg::CMD_EXEC:
                        begin
                            state_next = stop_reg ? S_RESULT : S_OP;
                        end
                        dsm_pkg::CMD_PORT_WR:
                        begin
                            pt_we      = (in_addr32 < Port32);
                            pt_waddr   = in_addr32[PAW-1:0];
                            pt_wdata   = value;
                            state_next = S_RESULT;
                        end
                        dsm_pkg::CMD_PORT_RD:
                        begin
                            pt_raddr   = in_addr32[PAW-1:0];
                            state_next = S_MEMRD;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_MEMRD:
            begin
                if (cmd_reg == dsm_pkg::CMD_MEM_RD)
                begin
                    rd_next = (addr32 < Img32) ? pm_rdata : 32'd0;
                end
                else
                begin
                    rd_next = (addr32 < Port32) ? pt_rdata : 32'd0;
                end
                state_next = S_RESULT;
            end

            // opcode, nos, return top and port 0 arrive; fetch the rest
            S_OP:
            begin
                op_next    = pm_rdata;
                nos_next   = ds_rdata;
                rtop_next  = rs_rdata;
                p0_next    = pt_rdata;
                argok_next = (ip1_32 < Img32);
                pm_raddr   = ip1_32[AW-1:0];
                ds_raddr   = dp_m2[DAW-1:0];
                if (pm_rdata == dsm_pkg::OP_IN && top_reg < Port32)
                begin
                    pt_raddr = top_reg[PAW-1:0];
                end
                else
                begin
                    pt_raddr = PQuery;
                end
                state_next = S_ARG;
            end

            // execute
            S_ARG:
            begin
                case (op_reg)
                    dsm_pkg::OP_NOP:
                    begin
                        fin = 1'b1;
                    end
                    dsm_pkg::OP_LIT, dsm_pkg::OP_DUP:
                    begin
                        if (!d_push)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            ds_we    = 1'b1;
                            ds_waddr = dp_reg[DAW-1:0];
                            ds_wdata = top_reg;
                            dp_next  = dp_reg + 1'b1;
                            fin      = 1'b1;
                            if (op_reg == dsm_pkg::OP_LIT)
                            begin
                                top_next = arg_w;
                                ip_fin   = {1'b0, ip_reg} + 2'd2;
                            end
                        end
                    end
                    dsm_pkg::OP_DROP:
                    begin
                        if (!d_pop1)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            top_next = nos_reg;
                            dp_next  = dp_m1;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_SWAP:
                    begin
                        if (!d_pop1)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            ds_we    = 1'b1;
                            ds_waddr = dp_m1[DAW-1:0];
                            ds_wdata = top_reg;
                            top_next = nos_reg;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_PUSH:
                    begin
                        if (!d_pop1 || !r_push)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            rs_we    = 1'b1;
                            rs_waddr = rp_reg[RAW-1:0];
                            rs_wdata = top_reg;
                            rp_next  = rp_reg + 1'b1;
                            top_next = nos_reg;
                            dp_next  = dp_m1;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_POP:
                    begin
                        if (!d_push || !r_pop)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            ds_we    = 1'b1;
                            ds_waddr = dp_reg[DAW-1:0];
                            ds_wdata = top_reg;
                            dp_next  = dp_reg + 1'b1;
                            top_next = rtop_reg;
                            rp_next  = rp_m1;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_LOOP:
                    begin
                        if (loop_n != 32'd0 && !loop_n[31])
                        begin
                            top_next = loop_n;
                            goto_req = 1'b1;
                            goto_t   = arg_w;
                        end
                        else if (!d_pop1)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            top_next = nos_reg;
                            dp_next  = dp_m1;
                            ip_fin   = {1'b0, ip_reg} + 2'd2;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_JUMP:
                    begin
                        goto_req  = 1'b1;
                        goto_skip = 1'b1;
                        goto_t    = arg_w;
                    end
                    dsm_pkg::OP_RETURN:
                    begin
                        if (!r_pop)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            rp_next  = rp_m1;
                            goto_req = 1'b1;
                            goto_t   = rtop_reg + 32'd1;
                        end
                    end
                    dsm_pkg::OP_GT_JMP, dsm_pkg::OP_LT_JMP,
                    dsm_pkg::OP_NE_JMP, dsm_pkg::OP_EQ_JMP:
                    begin
                        if (!d_pop2)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            dp_next  = dp_m2;
                            top_next = nos2_w;
                            if (taken_w)
                            begin
                                goto_req = 1'b1;
                                goto_t   = arg_w;
                            end
                            else
                            begin
                                ip_fin = {1'b0, ip_reg} + 2'd2;
                                fin    = 1'b1;
                            end
                        end
                    end
                    dsm_pkg::OP_FETCH:
                    begin
                        if (top_reg < Img32)
                        begin
                            pm_raddr   = top_reg[AW-1:0];
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            top_next = '0;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_STORE:
                    begin
                        if (!d_pop2)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            pm_we    = (top_reg < Img32);
                            pm_waddr = top_reg[AW-1:0];
                            pm_wdata = nos_reg;
                            dp_next  = dp_m2;
                            top_next = nos2_w;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_ADD, dsm_pkg::OP_SUB, dsm_pkg::OP_MUL,
                    dsm_pkg::OP_AND, dsm_pkg::OP_OR, dsm_pkg::OP_XOR,
                    dsm_pkg::OP_SHL, dsm_pkg::OP_SHR:
                    begin
                        if (!d_pop1)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            top_next = alu_w;
                            dp_next  = dp_m1;
                            fin      = 1'b1;
                        end
                    end
                    dsm_pkg::OP_DIVMOD:
                    begin
                        if (!d_pop1 || top_reg == 32'd0)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    dsm_pkg::OP_ZEXIT:
                    begin
                        if (top_reg != 32'd0)
                        begin
                            fin = 1'b1;
                        end
                        else if (!d_pop1 || !r_pop)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            top_next = nos_reg;
                            dp_next  = dp_m1;
                            rp_next  = rp_m1;
                            goto_req = 1'b1;
                            goto_t   = rtop_reg + 32'd1;
                        end
                    end
                    dsm_pkg::OP_INC:
                    begin
                        top_next = top_reg + 32'd1;
                        fin      = 1'b1;
                    end
                    dsm_pkg::OP_DEC:
                    begin
                        top_next = loop_n;
                        fin      = 1'b1;
                    end
                    dsm_pkg::OP_IN:
                    begin
                        if (top_reg < Port32)
                        begin
                            top_next = pdat_w;
                            pt_we    = 1'b1;
                            pt_waddr = top_reg[PAW-1:0];
                        end
                        else
                        begin
                            top_next = '0;
                        end
                        fin = 1'b1;
                    end
                    dsm_pkg::OP_OUT:
                    begin
                        if (!d_pop2)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            // port[top] written first, then port 0 cleared in S_OUT2 if top is another port
                            pt_we    = 1'b1;
                            dp_next  = dp_m2;
                            top_next = nos2_w;
                            if (top_reg < Port32)
                            begin
                                pt_waddr = top_reg[PAW-1:0];
                                pt_wdata = nos_reg;
                            end
                            if (top_reg < Port32 && top_reg != 32'd0)
                            begin
                                state_next = S_OUT2;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                    end
                    dsm_pkg::OP_WAIT:
                    begin
                        whalt_next = 1'b0;
                        if (p0_reg == 32'd1)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            io_next  = 1'b1;
                            pt_waddr = PQuery;
                            case (pdat_w)
                                dsm_pkg::Q_SIZE:
                                begin
                                    pt_we      = 1'b1;
                                    pt_wdata   = Img32;
                                    state_next = S_WAIT2;
                                end
                                dsm_pkg::Q_DDEPTH:
                                begin
                                    pt_we      = 1'b1;
                                    pt_wdata   = 32'(dp_reg);
                                    state_next = S_WAIT2;
                                end
                                dsm_pkg::Q_RDEPTH:
                                begin
                                    pt_we      = 1'b1;
                                    pt_wdata   = 32'(rp_reg);
                                    state_next = S_WAIT2;
                                end
                                dsm_pkg::Q_HALT:
                                begin
                                    pt_we      = 1'b1;
                                    io_next    = 1'b0;
                                    whalt_next = 1'b1;
                                    state_next = S_WAIT2;
                                end
                                default:
                                begin
                                    fin = 1'b1;
                                end
                            endcase
                        end
                    end
                    // any other cell: implicit call
                    default:
                    begin
                        if (!r_push)
                        begin
                            flt = 1'b1;
                        end
                        else
                        begin
                            rs_we     = 1'b1;
                            rs_waddr  = rp_reg[RAW-1:0];
                            rs_wdata  = ip32;
                            rp_next   = rp_reg + 1'b1;
                            goto_req  = 1'b1;
                            goto_skip = 1'b1;
                            goto_t    = op_reg;
                        end
                    end
                endcase
            end

            S_FETCH:
            begin
                top_next = pm_rdata;
                fin      = 1'b1;
            end

            // skip up to two NOP cells at the target
            S_SKIP1:
            begin
                if (pm_rdata == 32'd0)
                begin
                    if (skip_t < ImgIpX)
                    begin
                        tgt_next   = skip_t[IPW-1:0];
                        pm_raddr   = skip_t[AW-1:0];
                        state_next = S_SKIP2;
                    end
                    else
                    begin
                        ip_fin = skip_t;
                        fin    = 1'b1;
                    end
                end
                else
                begin
                    ip_fin = {1'b0, tgt_reg};
                    fin    = 1'b1;
                end
            end

            S_SKIP2:
            begin
                ip_fin = (pm_rdata == 32'd0) ? skip_t : {1'b0, tgt_reg};
                fin    = 1'b1;
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    top_next = q_w;
                    ds_we    = 1'b1;
                    ds_waddr = dp_m1[DAW-1:0];
                    ds_wdata = r_w;
                    fin      = 1'b1;
                end
            end

            S_OUT2:
            begin
                pt_we = 1'b1;
                fin   = 1'b1;
            end

            S_WAIT2:
            begin
                pt_we    = 1'b1;
                pt_wdata = 32'd1;
                ip_fin   = whalt_reg ? ImgIpX : ({1'b0, ip_reg} + 1'b1);
                fin      = 1'b1;
            end

            // load the output register once it is free
            S_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    o_rd_next    = rd_reg;
                    o_ip_next    = ip_reg;
                    o_top_next   = top_reg;
                    o_dp_next    = dp_reg;
                    o_rp_next    = rp_reg;
                    o_halt_next  = stop_reg;
                    o_io_next    = io_reg;
                    o_fault_next = fault_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // control transfer to a 32-bit target
        if (goto_req)
        begin
            if (goto_bad)
            begin
                ip_fin = ImgIpX;
                fin    = 1'b1;
            end
            else if (goto_skip)
            begin
                tgt_next   = goto_t[IPW-1:0];
                pm_raddr   = goto_t[AW-1:0];
                state_next = S_SKIP1;
            end
            else
            begin
                ip_fin = goto_t[IPW:0];
                fin    = 1'b1;
            end
        end

        if (flt)
        begin
            stop_next  = 1'b1;
            fault_next = 1'b1;
            state_next = S_RESULT;
        end

        if (fin)
        begin
            if (ip_fin >= ImgIpX)
            begin
                ip_next   = ImgIp;
                stop_next = 1'b1;
            end
            else
            begin
                ip_next = ip_fin[IPW-1:0];
            end
            state_next = S_RESULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ip_reg       <= '0;
            dp_reg       <= '0;
            rp_reg       <= '0;
            top_reg      <= '0;
            stop_reg     <= 1'b0;
            fault_reg    <= 1'b0;
            clr_reg      <= '0;
            cmd_reg      <= '0;
            addr_reg     <= '0;
            op_reg       <= '0;
            nos_reg      <= '0;
            rtop_reg     <= '0;
            p0_reg       <= '0;
            argok_reg    <= 1'b0;
            tgt_reg      <= '0;
            whalt_reg    <= 1'b0;
            rd_reg       <= '0;
            io_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            o_rd_reg     <= '0;
            o_ip_reg     <= '0;
            o_top_reg    <= '0;
            o_dp_reg     <= '0;
            o_rp_reg     <= '0;
            o_halt_reg   <= 1'b0;
            o_io_reg     <= 1'b0;
            o_fault_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ip_reg       <= ip_next;
            dp_reg       <= dp_next;
            rp_reg       <= rp_next;
            top_reg      <= top_next;
            stop_reg     <= stop_next;
            fault_reg    <= fault_next;
            clr_reg      <= clr_next;
            cmd_reg      <= cmd_next;
            addr_reg     <= addr_next;
            op_reg       <= op_next;
            nos_reg      <= nos_next;
            rtop_reg     <= rtop_next;
            p0_reg       <= p0_next;
            argok_reg    <= argok_next;
            tgt_reg      <= tgt_next;
            whalt_reg    <= whalt_next;
            rd_reg       <= rd_next;
            io_reg       <= io_next;
            ov_reg       <= ov_next;
            o_rd_reg     <= o_rd_next;
            o_ip_reg     <= o_ip_next;
            o_top_reg    <= o_top_next;
            o_dp_reg     <= o_dp_next;
            o_rp_reg     <= o_rp_next;
            o_halt_reg   <= o_halt_next;
            o_io_reg     <= o_io_next;
            o_fault_reg  <= o_fault_next;
        end
    end

    // ports
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign read_data    = o_rd_reg;
    assign next_address = 16'(32'(o_ip_reg));
    assign top_value    = o_top_reg;
    assign data_depth   = 8'(32'(o_dp_reg));
    assign return_depth = 11'(32'(o_rp_reg));
    assign halted       = o_halt_reg;
    assign io_request   = o_io_reg;
    assign fault        = o_fault_reg;

endmodule

// ----- rtl/dsm_checker.sv -----
// ----------------------------------------------------------------------------
// dsm_checker
// Port-level checks of the dual-stack machine result channel.
// ----------------------------------------------------------------------------
module dsm_checker #(
    parameter int IMAGE_WORDS = 32768,
    parameter int DATA_DEPTH  = 128
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic [15:0] next_address,
    input logic [7:0]  data_depth,
    input logic        halted,
    input logic        io_request,
    input logic        fault
);

    // a fault always stops the machine
    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> halted)
        else $error("fault without halted");

    // io requests only come from execute, which reads no data
    a_io_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && io_request |-> read_data == 32'd0)
        else $error("io_request with nonzero read_data");

    // a running machine points inside the image
    a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !halted |-> 32'(next_address) < 32'(IMAGE_WORDS))
        else $error("running with address outside the image");

    // data stack never deeper than its RAM
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(data_depth) <= 32'(DATA_DEPTH))
        else $error("data depth beyond capacity");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(next_address))
        else $error("result changed while stalled");

endmodule

bind dual_stack_machine_core dsm_checker #(
    .IMAGE_WORDS(IMAGE_WORDS),
    .DATA_DEPTH(DATA_DEPTH)
) u_dsm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .next_address(next_address),
    .data_depth(data_depth),
    .halted(halted),
    .io_request(io_request),
    .fault(fault)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: dual-stack machine core
// Checks every result of the core against a cycle-free model of the machine
// kept inside the bench. A short table of directed commands comes first,
// then random programs built one safe instruction at a time, with random
// memory and port traffic mixed in. The run ends with a divide-by-zero fault.
// ----------------------------------------------------------------------------
module testbench;
    import dsm_pkg::*;

    localparam int IMG   = 32768;
    localparam int DDEP  = 128;
    localparam int RDEP  = 1024;
    localparam int NPORT = 1024;
    localparam int ITEMS = 1650;
    localparam int TARGET_MAX = 31000;
    localparam logic [2:0] CMD_SPARE = 3'd7;

    typedef struct packed {
        logic [31:0] rdata;
        logic [15:0] nip;
        logic [31:0] tos;
        logic [7:0]  ddep;
        logic [10:0] rdep;
        logic        halt;
        logic        io;
        logic        flt;
    } result_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [14:0] addr;
        logic [31:0] val;
        bit          typed;
        result_t     exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [14:0] address;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic [15:0] next_address;
    logic [31:0] top_value;
    logic [7:0]  data_depth;
    logic [10:0] return_depth;
    logic        halted;
    logic        io_request;
    logic        fault;

    // machine image kept by the bench
    logic [31:0] mem_img [IMG];
    logic [31:0] dstk [DDEP];
    logic [31:0] rstk [RDEP];
    logic [31:0] port_img [NPORT];
    int unsigned ip_m, dp_m, rp_m;
    logic [31:0] tos_m;
    bit          stop_m, fault_m;

    result_t     expected_q [$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          execs = 0;

    dual_stack_machine_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .address(address), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .next_address(next_address),
        .top_value(top_value), .data_depth(data_depth),
        .return_depth(return_depth), .halted(halted),
        .io_request(io_request), .fault(fault)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #15ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] mem_read(logic [31:0] a);
        return (a < IMG) ? mem_img[a] : 32'd0;
    endfunction

    // stack bounds; a miss latches the fault
    function automatic bit has_room(int unsigned dn, int unsigned df,
                                    int unsigned rn, int unsigned rf);
        if (dp_m < dn || DDEP - dp_m < df || rp_m < rn || RDEP - rp_m < rf)
        begin
            stop_m  = 1'b1;
            fault_m = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void branch_to(logic [31:0] t, bit skip_nops);
        if (t[31] || t >= IMG)
        begin
            ip_m = IMG;
            return;
        end
        if (skip_nops)
            for (int k = 0; k < 2; k++)
                if (t < IMG && mem_img[t] == OP_NOP)
                    t++;
        ip_m = t;
    endfunction

    // one instruction; returns the host-service flag
    function automatic bit step_machine();
        logic [31:0] op, arg, a, b, q, r, ua, ub, n;
        bit          io, taken;
        io  = 1'b0;
        op  = mem_read(ip_m);
        arg = mem_read(ip_m + 1);
        case (op)
            OP_NOP: ip_m = ip_m + 1;
            OP_LIT:
            begin
                if (!has_room(0, 1, 0, 0)) return 1'b0;
                dstk[dp_m] = tos_m; dp_m++; tos_m = arg; ip_m = ip_m + 2;
            end
            OP_DUP:
            begin
                if (!has_room(0, 1, 0, 0)) return 1'b0;
                dstk[dp_m] = tos_m; dp_m++; ip_m = ip_m + 1;
            end
            OP_DROP:
            begin
                if (!has_room(1, 0, 0, 0)) return 1'b0;
                dp_m--; tos_m = dstk[dp_m]; ip_m = ip_m + 1;
            end
            OP_SWAP:
            begin
                if (!has_room(1, 0, 0, 0)) return 1'b0;
                a = dstk[dp_m-1]; dstk[dp_m-1] = tos_m; tos_m = a; ip_m = ip_m + 1;
            end
            OP_PUSH:
            begin
                if (!has_room(1, 0, 0, 1)) return 1'b0;
                rstk[rp_m] = tos_m; rp_m++; dp_m--; tos_m = dstk[dp_m];
                ip_m = ip_m + 1;
            end
            OP_POP:
            begin
                if (!has_room(0, 1, 1, 0)) return 1'b0;
                dstk[dp_m] = tos_m; dp_m++; rp_m--; tos_m = rstk[rp_m];
                ip_m = ip_m + 1;
            end
            OP_LOOP:
            begin
                n = tos_m - 1;
                taken = (n != 0) && !n[31];
                if (!taken && !has_room(1, 0, 0, 0)) return 1'b0;
                tos_m = n;
                if (taken) branch_to(arg, 1'b0);
                else
                begin
                    dp_m--; tos_m = dstk[dp_m]; ip_m = ip_m + 2;
                end
            end
            OP_JUMP: branch_to(arg, 1'b1);
            OP_RETURN:
            begin
                if (!has_room(0, 0, 1, 0)) return 1'b0;
                rp_m--; branch_to(rstk[rp_m] + 1, 1'b0);
            end
            OP_GT_JMP, OP_LT_JMP, OP_NE_JMP, OP_EQ_JMP:
            begin
                if (!has_room(2, 0, 0, 0)) return 1'b0;
                b = dstk[dp_m-1];
                a = tos_m;
                if (op == OP_GT_JMP)      taken = $signed(a) < $signed(b);
                else if (op == OP_LT_JMP) taken = $signed(b) < $signed(a);
                else if (op == OP_NE_JMP) taken = a != b;
                else                      taken = a == b;
                dp_m -= 2; tos_m = dstk[dp_m];
                if (taken) branch_to(arg, 1'b0);
                else ip_m = ip_m + 2;
            end
            OP_FETCH:
            begin
                tos_m = mem_read(tos_m); ip_m = ip_m + 1;
            end
            OP_STORE:
            begin
                if (!has_room(2, 0, 0, 0)) return 1'b0;
                if (tos_m < IMG) mem_img[tos_m] = dstk[dp_m-1];
                dp_m -= 2; tos_m = dstk[dp_m]; ip_m = ip_m + 1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
            begin
                if (!has_room(1, 0, 0, 0)) return 1'b0;
                a = tos_m; dp_m--; b = dstk[dp_m];
                case (op)
                    OP_ADD:  r = b + a;
                    OP_SUB:  r = b - a;
                    OP_MUL:  r = b * a;
                    OP_AND:  r = b & a;
                    OP_OR:   r = b | a;
                    OP_XOR:  r = b ^ a;
                    OP_SHL:  r = b << a[4:0];
                    default: r = $signed(b) >>> a[4:0];
                endcase
                tos_m = r; ip_m = ip_m + 1;
            end
            OP_DIVMOD:
            begin
                if (!has_room(1, 0, 0, 0)) return 1'b0;
                a = tos_m; b = dstk[dp_m-1];
                if (a == 0)
                begin
                    stop_m = 1'b1; fault_m = 1'b1;
                    return 1'b0;
                end
                ua = a[31] ? -a : a;
                ub = b[31] ? -b : b;
                q = ub / ua; r = ub % ua;
                if (a[31] ^ b[31]) q = -q;
                if (b[31]) r = -r;
                tos_m = q; dstk[dp_m-1] = r; ip_m = ip_m + 1;
            end
            OP_ZEXIT:
            begin
                if (tos_m == 0)
                begin
                    if (!has_room(1, 0, 1, 0)) return 1'b0;
                    dp_m--; tos_m = dstk[dp_m];
                    rp_m--; branch_to(rstk[rp_m] + 1, 1'b0);
                end
                else ip_m = ip_m + 1;
            end
            OP_INC:
            begin
                tos_m = tos_m + 1; ip_m = ip_m + 1;
            end
            OP_DEC:
            begin
                tos_m = tos_m - 1; ip_m = ip_m + 1;
            end
            OP_IN:
            begin
                a = tos_m;
                if (a < NPORT)
                begin
                    tos_m = port_img[a]; port_img[a] = 0;
                end
                else tos_m = 0;
                ip_m = ip_m + 1;
            end
            OP_OUT:
            begin
                if (!has_room(2, 0, 0, 0)) return 1'b0;
                port_img[0] = 0;
                if (tos_m < NPORT) port_img[tos_m] = dstk[dp_m-1];
                dp_m -= 2; tos_m = dstk[dp_m]; ip_m = ip_m + 1;
            end
            OP_WAIT:
            begin
                ip_m = ip_m + 1;
                if (port_img[0] != 1)
                begin
                    q = port_img[PORT_QUERY];
                    io = 1'b1;
                    if (q == Q_SIZE)
                    begin
                        port_img[PORT_QUERY] = IMG; port_img[0] = 1;
                    end
                    else if (q == Q_DDEPTH)
                    begin
                        port_img[PORT_QUERY] = dp_m; port_img[0] = 1;
                    end
                    else if (q == Q_RDEPTH)
                    begin
                        port_img[PORT_QUERY] = rp_m; port_img[0] = 1;
                    end
                    else if (q == Q_HALT)
                    begin
                        port_img[PORT_QUERY] = 0; port_img[0] = 1;
                        ip_m = IMG; io = 1'b0;
                    end
                end
            end
            default:
            begin
                // any other cell calls that address
                if (!has_room(0, 0, 0, 1)) return 1'b0;
                rstk[rp_m] = ip_m; rp_m++;
                branch_to(op, 1'b1);
            end
        endcase
        if (ip_m >= IMG)
        begin
            ip_m = IMG;
            stop_m = 1'b1;
        end
        return io;
    endfunction

    // apply one command to the image and form its result
    function automatic result_t apply_command(logic [2:0] cmd, logic [14:0] addr,
                                              logic [31:0] val);
        result_t res;
        res = '0;
        case (cmd)
            CMD_MEM_WR:  mem_img[addr] = val;
            CMD_MEM_RD:  res.rdata = mem_img[addr];
            CMD_EXEC:    if (!stop_m) res.io = step_machine();
            CMD_PORT_WR: if (addr < NPORT) port_img[addr] = val;
            CMD_PORT_RD: if (addr < NPORT) res.rdata = port_img[addr];
            default: ;
        endcase
        res.nip  = ip_m[15:0];
        res.tos  = tos_m;
        res.ddep = dp_m[7:0];
        res.rdep = rp_m[10:0];
        res.halt = stop_m;
        res.flt  = fault_m;
        return res;
    endfunction

    // would this instruction at ip keep the machine running
    function automatic bit keeps_running(logic [31:0] op, logic [31:0] arg);
        logic [31:0] n, ret;
        ret = (rp_m > 0) ? rstk[rp_m-1] : 32'hFFFF_FFFF;
        case (op)
            OP_NOP, OP_FETCH, OP_INC, OP_DEC, OP_IN, OP_JUMP: return 1'b1;
            OP_LIT, OP_DUP: return dp_m < DDEP;
            OP_DROP, OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR: return dp_m >= 1;
            OP_PUSH: return dp_m >= 1 && rp_m < RDEP;
            OP_POP: return dp_m < DDEP && rp_m >= 1;
            OP_LOOP:
            begin
                n = tos_m - 1;
                return ((n != 0) && !n[31]) || dp_m >= 1;
            end
            OP_RETURN: return rp_m >= 1 && ret < TARGET_MAX;
            OP_GT_JMP, OP_LT_JMP, OP_NE_JMP, OP_EQ_JMP, OP_STORE, OP_OUT:
                return dp_m >= 2;
            OP_DIVMOD: return dp_m >= 1 && tos_m != 0;
            OP_ZEXIT: return tos_m != 0 || (dp_m >= 1 && rp_m >= 1 && ret < TARGET_MAX);
            OP_WAIT: return port_img[0] == 1 || port_img[PORT_QUERY] != Q_HALT;
            default: return rp_m < RDEP;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 40);
            4: return $urandom_range(0, 1100);
            default: return $urandom;
        endcase
    endfunction

    // sender: one transfer on the input channel
    task automatic send_command(logic [2:0] cmd, logic [14:0] addr, logic [31:0] val,
                                bit typed, result_t typed_res);
        int      gap;
        result_t res;
        gap = ((sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= addr;
        value    <= val;
        do @(posedge clk); while (!(in_valid && in_ready));
        res = apply_command(cmd, addr, val);
        expected_q.push_back(typed ? typed_res : res);
        sent++;
        if (cmd == CMD_EXEC) execs++;
    endtask

    task automatic send_plain(logic [2:0] cmd, logic [14:0] addr, logic [31:0] val);
        send_command(cmd, addr, val, 1'b0, '0);
    endtask

    // build a safe instruction at ip and execute it
    task automatic random_instruction();
        logic [31:0] op, arg;
        int          k;
        bit          ok;
        ok = 1'b0;
        if (ip_m > 31900)
        begin
            op = OP_JUMP; arg = $urandom_range(0, TARGET_MAX); ok = 1'b1;
        end
        for (int t = 0; t < 20 && !ok; t++)
        begin
            k  = $urandom_range(0, 31);
            op = (k < 31) ? k : $urandom_range(31, TARGET_MAX);
            if (op == OP_LOOP || (op >= OP_JUMP && op <= OP_EQ_JMP))
                arg = $urandom_range(0, TARGET_MAX);
            else
                arg = pick_word();
            ok = keeps_running(op, arg);
        end
        if (!ok)
        begin
            op = OP_NOP; arg = 0;
        end
        // sometimes plant a NOP at the target to exercise the skip
        if ((op == OP_JUMP || op > OP_WAIT) && $urandom_range(0, 2) == 0)
            send_plain(CMD_MEM_WR, (op == OP_JUMP) ? arg[14:0] : op[14:0], OP_NOP);
        send_plain(CMD_MEM_WR, ip_m[14:0], op);
        if (op == OP_LIT || op == OP_LOOP || (op >= OP_JUMP && op <= OP_EQ_JMP))
            send_plain(CMD_MEM_WR, ip_m[14:0] + 15'd1, arg);
        send_plain(CMD_EXEC, $urandom, $urandom);
    endtask

    // memory and port traffic between instructions
    task automatic random_traffic();
        logic [2:0]  cmd;
        logic [14:0] addr;
        logic [31:0] val;
        cmd  = $urandom_range(0, 6);
        if (cmd == CMD_EXEC) cmd = CMD_SPARE;
        addr = $urandom;
        val  = pick_word();
        if (cmd == CMD_PORT_WR || cmd == CMD_PORT_RD)
        begin
            case ($urandom_range(0, 3))
                0: addr = PORT_QUERY;
                1: addr = 0;
                2: addr = $urandom_range(0, NPORT - 1);
                default: ;
            endcase
            if (cmd == CMD_PORT_WR && addr == PORT_QUERY)
                case ($urandom_range(0, 4))
                    0: val = Q_SIZE;
                    1: val = Q_DDEPTH;
                    2: val = Q_RDEPTH;
                    3: val = Q_HALT;
                    default: ;
                endcase
            if (cmd == CMD_PORT_WR && addr == 0) val = $urandom_range(0, 2);
        end
        send_plain(cmd, addr, val);
    endtask

    function automatic result_t expect_of(logic [31:0] rd, logic [15:0] nip,
                                          logic [31:0] tos, logic [7:0] dd,
                                          logic [10:0] rdp, logic io);
        result_t res;
        res = '0;
        res.rdata = rd; res.nip = nip; res.tos = tos;
        res.ddep = dd; res.rdep = rdp; res.io = io;
        return res;
    endfunction

    // receiver: draws stalls, compares each transfer with the oldest expectation
    initial
    begin : receiver
        int      stall;
        result_t got, want;
        out_ready <= 1'b0;
        forever
        begin
            if (received == 500)
                stall = 400;
            else if ((received / 170) % 4 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            received++;
            got = '{read_data, next_address, top_value, data_depth, return_depth,
                    halted, io_request, fault};
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result %0d mismatch: rd %h/%h ip %h/%h tos %h/%h ",
                                  "dd %h/%h rd %h/%h halt %b/%b io %b/%b fault %b/%b"},
                                 received, want.rdata, got.rdata, want.nip, got.nip,
                                 want.tos, got.tos, want.ddep, got.ddep, want.rdep,
                                 got.rdep, want.halt, got.halt, want.io, got.io,
                                 want.flt, got.flt);
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        row_t rows [$];
        bit   paused;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = '0;
        address  = '0;
        value    = '0;
        paused   = 1'b0;
        foreach (mem_img[i]) mem_img[i] = '0;
        foreach (dstk[i]) dstk[i] = '0;
        foreach (rstk[i]) rstk[i] = '0;
        foreach (port_img[i]) port_img[i] = '0;
        ip_m = 0; dp_m = 0; rp_m = 0; tos_m = '0;
        stop_m = 1'b0; fault_m = 1'b0;

        // directed table: reset contents, extremes, /MOD overflow case,
        // answered query, call with NOP skip, return
        rows.push_back('{CMD_MEM_RD, 15'd0, 32'd0, 1, expect_of(0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_PORT_RD, 15'h7FFF, 32'd0, 1, expect_of(0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_SPARE, 15'h7FFF, 32'hFFFF_FFFF, 1,
                         expect_of(0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_MEM_WR, 15'h7FFF, 32'h7FFF_FFFF, 1,
                         expect_of(0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_MEM_RD, 15'h7FFF, 32'd0, 1,
                         expect_of(32'h7FFF_FFFF, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_PORT_WR, 15'd1023, 32'hFFFF_FFFF, 0, '0});
        rows.push_back('{CMD_PORT_RD, 15'd1023, 32'd0, 0, '0});
        rows.push_back('{CMD_MEM_WR, 15'd0, OP_LIT, 0, '0});
        rows.push_back('{CMD_MEM_WR, 15'd1, 32'h8000_0000, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 2, 32'h8000_0000, 1, 0, 0)});
        rows.push_back('{CMD_MEM_WR, 15'd2, OP_LIT, 0, '0});
        rows.push_back('{CMD_MEM_WR, 15'd3, 32'hFFFF_FFFF, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 4, 32'hFFFF_FFFF, 2, 0, 0)});
        rows.push_back('{CMD_MEM_WR, 15'd4, OP_DIVMOD, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 5, 32'h8000_0000, 2, 0, 0)});
        rows.push_back('{CMD_PORT_WR, 15'd5, Q_SIZE, 0, '0});
        rows.push_back('{CMD_MEM_WR, 15'd5, OP_WAIT, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 6, 32'h8000_0000, 2, 0, 1)});
        rows.push_back('{CMD_PORT_RD, 15'd5, 32'd0, 1,
                         expect_of(IMG, 6, 32'h8000_0000, 2, 0, 0)});
        rows.push_back('{CMD_MEM_WR, 15'd6, 32'd32000, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 32002, 32'h8000_0000, 2, 1, 0)});
        rows.push_back('{CMD_MEM_WR, 15'd32002, OP_RETURN, 0, '0});
        rows.push_back('{CMD_EXEC, 15'd0, 32'd0, 1,
                         expect_of(0, 7, 32'h8000_0000, 2, 0, 0)});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_command(rows[i].cmd, rows[i].addr, rows[i].val, rows[i].typed,
                         rows[i].exp);

        // random programs with traffic mixed in
        while (sent < ITEMS)
        begin
            if (!paused && sent >= 900)
            begin
                // sender holds until the core has drained
                paused = 1'b1;
                in_valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                random_traffic();
            else
                random_instruction();
        end

        // closing fault: divide by zero, then execute while stopped
        send_plain(CMD_MEM_WR, ip_m[14:0], OP_LIT);
        send_plain(CMD_MEM_WR, ip_m[14:0] + 15'd1, 32'd0);
        send_plain(CMD_EXEC, 15'd0, 32'd0);
        send_plain(CMD_MEM_WR, ip_m[14:0], OP_DIVMOD);
        send_plain(CMD_EXEC, 15'd0, 32'd0);
        send_plain(CMD_EXEC, 15'd0, 32'd0);
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d transfers, %0d instructions executed, final fault %b",
                 sent, execs, fault_m);
        $display("directed table of %0d rows, random programs and port traffic",
                 rows.size());
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dsm_pkg.sv
rtl/dsm_ram.sv
rtl/dsm_div.sv
rtl/dual_stack_machine_core.sv
rtl/dsm_checker.sv
sim/testbench.sv
